FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// concurrent checks on clk_i with reset rst_ni, removed for synthesis
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_AT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define ASSERT_AT(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

FILE: rtl/asl_pkg.sv
// ---------------------------------------------------------------------------
// asl_pkg
// shared types, codes and character classes of the source lexer
// ---------------------------------------------------------------------------
package asl_pkg;

  localparam int unsigned MAX_TEXT = 31;

  // token kinds
  localparam logic [3:0] K_ENDF  = 4'd0;
  localparam logic [3:0] K_ENDL  = 4'd1;
  localparam logic [3:0] K_INT   = 4'd2;
  localparam logic [3:0] K_HEX   = 4'd3;
  localparam logic [3:0] K_OCT   = 4'd4;
  localparam logic [3:0] K_SYM   = 4'd5;
  localparam logic [3:0] K_LABEL = 4'd6;
  localparam logic [3:0] K_SIGN  = 4'd7;
  localparam logic [3:0] K_ADDR  = 4'd8;

  // lexer modes
  localparam logic [3:0] M_IDLE    = 4'd0;
  localparam logic [3:0] M_SKIP    = 4'd1;
  localparam logic [3:0] M_ZERO    = 4'd2;
  localparam logic [3:0] M_OCT     = 4'd3;
  localparam logic [3:0] M_HEX     = 4'd4;
  localparam logic [3:0] M_DEC     = 4'd5;
  localparam logic [3:0] M_SYM     = 4'd6;
  localparam logic [3:0] M_HEXLOOK = 4'd7;
  localparam logic [3:0] M_SYMLOOK = 4'd8;

  // characters
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_X      = 8'h78;

  typedef struct packed {
    logic       is_token_end;
    logic [3:0] token_kind;
    logic [7:0] text_char;
    logic [4:0] text_length;
  } res_t;

  function automatic logic is_dig(logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_oct(logic [7:0] c);
    return c inside {[8'h30:8'h37]};
  endfunction

  function automatic logic is_hex(logic [7:0] c);
    return c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
  endfunction

  function automatic logic is_word_ch(logic [7:0] c);
    return (c == CH_USCORE) || (c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]});
  endfunction

  function automatic res_t mk_echo(logic [7:0] c);
    res_t r;
    r.is_token_end = 1'b0;
    r.token_kind   = K_ENDF;
    r.text_char    = c;
    r.text_length  = 5'd0;
    return r;
  endfunction

  function automatic res_t mk_end(logic [3:0] kind, logic [4:0] len);
    res_t r;
    r.is_token_end = 1'b1;
    r.token_kind   = kind;
    r.text_char    = 8'd0;
    r.text_length  = len;
    return r;
  endfunction

endpackage

FILE: rtl/asl_if.sv
// ---------------------------------------------------------------------------
// asl_in_if / asl_out_if
// valid/ready channels for source characters and lexer results
// ---------------------------------------------------------------------------
interface asl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] source_char;
  logic       end_of_input;

  modport source (output valid, source_char, end_of_input, input ready);
  modport sink   (input valid, source_char, end_of_input, output ready);
endinterface

interface asl_out_if;
  logic       valid;
  logic       ready;
  logic       is_token_end;
  logic [3:0] token_kind;
  logic [7:0] text_char;
  logic [4:0] text_length;
  logic       last_of_run;

  modport source (output valid, is_token_end, token_kind, text_char, text_length,
                  last_of_run, input ready);
  modport sink   (input valid, is_token_end, token_kind, text_char, text_length,
                  last_of_run, output ready);
endinterface

FILE: rtl/asl_step.sv
// ---------------------------------------------------------------------------
// asl_step
// one pass of the lexer mode logic on one character
// ---------------------------------------------------------------------------
module asl_step #(
  parameter int unsigned MaxText = asl_pkg::MAX_TEXT,
  parameter int unsigned KeptW   = $clog2(MaxText + 1)
) (
  input  logic [3:0]              mode_i,
  input  logic [KeptW-1:0]        kept_i,
  input  logic [7:0]              char_i,
  input  logic                    eof_i,
  output logic [3:0]              mode_o,
  output logic [KeptW-1:0]        kept_o,
  output logic                    again_o,
  output logic [1:0]              n_o,
  output asl_pkg::res_t [1:0]     res_o
);
  import asl_pkg::*;

  logic can_keep;
  logic blank;
  logic look_hex;

  assign can_keep = kept_i < KeptW'(MaxText);
  assign blank    = !eof_i && (char_i <= CH_SPACE) && (char_i != CH_LF);
  assign look_hex = (mode_i == M_HEXLOOK);

  always_comb begin
    mode_o  = mode_i;
    kept_o  = kept_i;
    again_o = 1'b0;
    n_o     = 2'd0;
    res_o   = '0;
    case (mode_i)
      M_IDLE: begin
        kept_o = '0;
        if (eof_i) begin
          res_o[0] = mk_end(K_ENDF, 5'd0);
          n_o      = 2'd1;
        end else if (char_i == CH_LF) begin
          res_o[0] = mk_end(K_ENDL, 5'd0);
          n_o      = 2'd1;
        end else if (char_i == CH_SEMI) begin
          mode_o = M_SKIP;
        end else if (char_i <= CH_SPACE) begin
          mode_o = M_IDLE;
        end else begin
          res_o[0] = mk_echo(char_i);
          n_o      = 2'd1;
          kept_o   = KeptW'(1);
          if (char_i == CH_ZERO) begin
            mode_o = M_ZERO;
          end else if (is_dig(char_i)) begin
            mode_o = M_DEC;
          end else if (is_word_ch(char_i)) begin
            mode_o = M_SYM;
          end else begin
            res_o[1] = mk_end(K_SIGN, 5'd1);
            n_o      = 2'd2;
            kept_o   = '0;
          end
        end
      end
      M_SKIP: begin
        if (eof_i || char_i == CH_LF) begin
          res_o[0] = mk_end(K_ENDL, 5'(kept_i));
          n_o      = 2'd1;
          kept_o   = '0;
          mode_o   = M_IDLE;
          again_o  = eof_i;
        end
      end
      M_ZERO: begin
        if (!eof_i && is_dig(char_i)) begin
          mode_o  = M_OCT;
          again_o = 1'b1;
        end else if (!eof_i && char_i == CH_X) begin
          mode_o = M_HEX;
          if (can_keep) begin
            res_o[0] = mk_echo(char_i);
            n_o      = 2'd1;
            kept_o   = kept_i + KeptW'(1);
          end
        end else begin
          res_o[0] = mk_end(K_INT, 5'(kept_i));
          n_o      = 2'd1;
          kept_o   = '0;
          mode_o   = M_IDLE;
          again_o  = 1'b1;
        end
      end
      M_OCT, M_DEC: begin
        if (!eof_i && ((mode_i == M_OCT) ? is_oct(char_i) : is_dig(char_i))) begin
          if (can_keep) begin
            res_o[0] = mk_echo(char_i);
            n_o      = 2'd1;
            kept_o   = kept_i + KeptW'(1);
          end
        end else begin
          res_o[0] = mk_end((mode_i == M_OCT) ? K_OCT : K_INT, 5'(kept_i));
          n_o      = 2'd1;
          kept_o   = '0;
          mode_o   = M_IDLE;
          again_o  = 1'b1;
        end
      end
      M_HEX, M_SYM: begin
        if (!eof_i && ((mode_i == M_HEX) ? is_hex(char_i) : is_word_ch(char_i))) begin
          if (can_keep) begin
            res_o[0] = mk_echo(char_i);
            n_o      = 2'd1;
            kept_o   = kept_i + KeptW'(1);
          end
        end else begin
          mode_o  = (mode_i == M_HEX) ? M_HEXLOOK : M_SYMLOOK;
          again_o = 1'b1;
        end
      end
      M_HEXLOOK, M_SYMLOOK: begin
        if (!blank) begin
          n_o    = 2'd1;
          kept_o = '0;
          mode_o = M_IDLE;
          if (!eof_i && char_i == CH_COLON) begin
            res_o[0] = mk_end(look_hex ? K_ADDR : K_LABEL, 5'(kept_i));
          end else begin
            res_o[0] = mk_end(look_hex ? K_HEX : K_SYM, 5'(kept_i));
            again_o  = 1'b1;
          end
        end
      end
      default: begin
        mode_o  = M_IDLE;
        kept_o  = '0;
        again_o = 1'b1;
      end
    endcase
  end

endmodule

FILE: rtl/asl_res_buf.sv
// ---------------------------------------------------------------------------
// asl_res_buf
// holds the results of one character and hands them out one per cycle while out_o.ready is high
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module asl_res_buf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  logic [1:0]           n_i,
  input  asl_pkg::res_t [2:0]  res_i,
  output logic                 load_ok_o,
  asl_out_if.source            out_o
);
  import asl_pkg::*;

  res_t [2:0] buf_q;
  logic [1:0] left_q, left_d;
  logic       pop;

  assign pop       = out_o.valid && out_o.ready;
  assign load_ok_o = (left_q == 2'd0) || (left_q == 2'd1 && out_o.ready);

  always_comb begin
    left_d = left_q;
    if (load_i) begin
      left_d = n_i;
    end else if (pop) begin
      left_d = left_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= 2'd0;
    end else begin
      left_q <= left_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      buf_q <= res_i;
    end else if (pop) begin
      buf_q[0] <= buf_q[1];
      buf_q[1] <= buf_q[2];
    end
  end

  assign out_o.valid        = (left_q != 2'd0);
  assign out_o.is_token_end = buf_q[0].is_token_end;
  assign out_o.token_kind   = buf_q[0].token_kind;
  assign out_o.text_char    = buf_q[0].text_char;
  assign out_o.text_length  = buf_q[0].text_length;
  assign out_o.last_of_run  = (left_q == 2'd1);

  `ASSERT_NEVER(no_overwrite, load_i && left_q > 2'd1, "load over pending results")
  `ASSERT_NEVER(no_lost_pop, load_i && left_q == 2'd1 && !pop, "load over unsent result")
  `ASSERT_AT(load_count, load_i |=> left_q == $past(n_i), "result count not loaded")
  `ASSERT_AT(run_continues, (pop && left_q > 2'd1) |=> out_o.valid, "run cut short")

endmodule

FILE: rtl/assembler_source_lexer.sv
// ---------------------------------------------------------------------------
// assembler_source_lexer
// splits a stream of source bytes into assembler tokens
// ---------------------------------------------------------------------------
// in_i takes one source byte, or an end-of-input flag, per item. out_o gives
// result items: an echo of each kept token character, or a token end with
// kind and kept length. last_of_run marks the final result of one input
// item; an item that only skips or drops bytes gives no result.
// An input item waits in the input register while the mode logic (up to
// four chained passes over that byte) works on it, and its results are
// loaded into the result buffer once the buffer can take them; the first
// result is offered from that buffer register.
// One input item is accepted per cycle while items give at most one result
// and the receiver is ready; an item with more results keeps the next item
// waiting, as the result buffer drains one result per cycle while ready.
// When the receiver stalls, the buffer and then the input register fill and
// in_i.ready drops. Reset returns the lexer to idle between tokens with a
// kept length of zero and empties both registers.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module assembler_source_lexer #(
  parameter int unsigned MaxText = asl_pkg::MAX_TEXT
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  asl_in_if.sink    in_i,
  asl_out_if.source out_o
);
  import asl_pkg::*;

  localparam int unsigned KeptW  = $clog2(MaxText + 1);
  localparam int unsigned Passes = 4;

  logic             in_vld_q, in_vld_d;
  logic [7:0]       char_q;
  logic             eof_q;
  logic [3:0]       mode_q;
  logic [KeptW-1:0] kept_q;
  logic             load_ok;
  logic             step_fire;
  logic             in_take;

  logic [3:0]       mode_s [Passes+1];
  logic [KeptW-1:0] kept_s [Passes+1];
  logic             act_s  [Passes+1];
  logic [3:0]       mode_p [Passes];
  logic [KeptW-1:0] kept_p [Passes];
  logic             again_p[Passes];
  logic [1:0]       n_p    [Passes];
  res_t [1:0]       res_p  [Passes];

  res_t [2:0]       acc;
  logic [1:0]       acc_n;

  assign step_fire = in_vld_q && load_ok;
  assign in_i.ready = !in_vld_q || load_ok;
  assign in_take   = in_i.valid && in_i.ready;

  assign mode_s[0] = mode_q;
  assign kept_s[0] = kept_q;
  assign act_s[0]  = 1'b1;

  for (genvar p = 0; p < Passes; p++) begin : g_pass
    asl_step #(
      .MaxText (MaxText),
      .KeptW   (KeptW)
    ) u_step (
      .mode_i  (mode_s[p]),
      .kept_i  (kept_s[p]),
      .char_i  (char_q),
      .eof_i   (eof_q),
      .mode_o  (mode_p[p]),
      .kept_o  (kept_p[p]),
      .again_o (again_p[p]),
      .n_o     (n_p[p]),
      .res_o   (res_p[p])
    );
    assign mode_s[p+1] = act_s[p] ? mode_p[p] : mode_s[p];
    assign kept_s[p+1] = act_s[p] ? kept_p[p] : kept_s[p];
    assign act_s[p+1]  = act_s[p] && again_p[p];
  end

  // pack the results of the active passes, at most three
  always_comb begin
    acc   = '0;
    acc_n = 2'd0;
    for (int p = 0; p < Passes; p++) begin
      for (int j = 0; j < 2; j++) begin
        if (act_s[p] && (2'(j) < n_p[p]) && (acc_n != 2'd3)) begin
          acc[acc_n] = res_p[p][j];
          acc_n      = acc_n + 2'd1;
        end
      end
    end
  end

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_take) begin
      in_vld_d = 1'b1;
    end else if (step_fire) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      mode_q   <= M_IDLE;
      kept_q   <= '0;
    end else begin
      in_vld_q <= in_vld_d;
      if (step_fire) begin
        mode_q <= mode_s[Passes];
        kept_q <= kept_s[Passes];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      char_q <= in_i.source_char;
      eof_q  <= in_i.end_of_input;
    end
  end

  asl_res_buf u_res_buf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (step_fire),
    .n_i       (acc_n),
    .res_i     (acc),
    .load_ok_o (load_ok),
    .out_o     (out_o)
  );

  `ASSERT_AT(kept_bounded, kept_q <= KeptW'(MaxText), "kept length beyond limit")
  `ASSERT_NEVER(eof_silent, step_fire && eof_q && acc_n == 2'd0, "end of input gave no result")
  `ASSERT_AT(held_input, (in_vld_q && !step_fire) |=> in_vld_q && $stable(char_q),
             "waiting input item lost")

endmodule
